// ===== design/dq_pkg.sv =====
// shared types and constants for the double-ended queue
// no dependencies; compiled first
package dq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // per-cycle command broadcast along one row of cells
  typedef struct packed {
    logic shift_in;   // every cell takes its lower neighbor, cell 0 takes the new value
    logic shift_out;  // every cell takes its upper neighbor
    logic load;       // the cell whose index matches takes the new value
  } shift_ctrl_t;

endpackage

// ===== design/dq_if.sv =====
// valid/ready channel interfaces for the double-ended queue
// depends on dq_pkg
interface dq_in_if;
  import dq_pkg::*;
  logic                valid;
  logic                ready;
  op_e                 operation;
  logic [DATA_W-1:0]   push_value;

  modport source (output valid, operation, push_value, input ready);
  modport sink   (input valid, operation, push_value, output ready);
endinterface

interface dq_out_if;
  import dq_pkg::*;
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   pop_value;
  status_e             status;
  logic                now_empty;
  logic                now_full;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, pop_value, status, now_empty, now_full, entry_count,
                  input ready);
  modport sink   (input valid, pop_value, status, now_empty, now_full, entry_count,
                  output ready);
endinterface

// ===== design/dq_cell.sv =====
// one storage cell of a shifting row
// depends on dq_pkg
module dq_cell
  import dq_pkg::*;
#(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned IW    = 4,
  parameter int unsigned INDEX = 0
) (
  input  logic             clk_i,
  input  shift_ctrl_t      ctrl_i,
  input  logic [IW-1:0]    idx_i,
  input  logic [WIDTH-1:0] value_i,
  input  logic [WIDTH-1:0] lower_i,
  input  logic [WIDTH-1:0] upper_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_in) begin
      data_d = lower_i;
    end else if (ctrl_i.shift_out) begin
      data_d = upper_i;
    end else if (ctrl_i.load && (idx_i == IW'(INDEX))) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== design/dq_chain.sv =====
// row of cells with the head fixed at cell 0
// depends on dq_pkg and dq_cell
module dq_chain
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                       clk_i,
  input  shift_ctrl_t                ctrl_i,
  input  logic [$clog2(DEPTH)-1:0]   idx_i,
  input  logic [WIDTH-1:0]           value_i,
  output logic [WIDTH-1:0]           head_o
);

  localparam int unsigned IW = $clog2(DEPTH);

  logic [WIDTH-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] lower, upper;

    if (i == 0) begin : g_first
      assign lower = value_i;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end

    // the far end refills with its own stale value, it lies beyond the count
    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end

    dq_cell #(
      .WIDTH (WIDTH),
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .idx_i   (idx_i),
      .value_i (value_i),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule

// ===== design/double_ended_queue.sv =====
// double-ended queue: result shown the cycle after acceptance, one item per cycle
// sustained while results are taken; the output register limits the rate only on stall
// two rows of cells, one with the front entry at cell 0 and one with the back at cell 0,
// so every pop reads a fixed cell and every push shifts one row and loads the other
// reset (async, active low) empties the queue and drops any pending result; cell
// contents are not cleared and are never read before written
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    in_i,
  dq_out_if.source out_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  // input field is DATA_W wide, so nothing above it is ever stored
  localparam int unsigned SW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

  // control state
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q;

  // result payload
  logic [SW-1:0] pop_q, pop_d;
  status_e       status_q, status_d;

  logic          fire;
  logic          is_full, is_empty;
  logic          front_push_ok, back_push_ok, front_pop_ok, back_pop_ok;
  shift_ctrl_t   front_ctrl, back_ctrl;
  logic [SW-1:0] front_head, back_head;
  logic [SW-1:0] value_in;

  // next item may enter as soon as the pending result leaves
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;

  assign is_full  = (count_q == CW'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign value_in = in_i.push_value[SW-1:0];

  // decode the operation against the current fill level
  always_comb begin
    front_push_ok = 1'b0;
    back_push_ok  = 1'b0;
    front_pop_ok  = 1'b0;
    back_pop_ok   = 1'b0;
    status_d      = ST_OK;
    case (in_i.operation)
      OP_PUSH_BACK: begin
        if (is_full) status_d = ST_FULL;
        else         back_push_ok = 1'b1;
      end
      OP_PUSH_FRONT: begin
        if (is_full) status_d = ST_FULL;
        else         front_push_ok = 1'b1;
      end
      OP_POP_BACK: begin
        if (is_empty) status_d = ST_EMPTY;
        else          back_pop_ok = 1'b1;
      end
      OP_POP_FRONT: begin
        if (is_empty) status_d = ST_EMPTY;
        else          front_pop_ok = 1'b1;
      end
      default: status_d = ST_OK;
    endcase
  end

  // front row: entry 0 is the front; a back push lands at the current count
  assign front_ctrl.shift_in  = fire && front_push_ok;
  assign front_ctrl.shift_out = fire && front_pop_ok;
  assign front_ctrl.load      = fire && back_push_ok;

  // back row: entry 0 is the back; a front push lands at the current count
  assign back_ctrl.shift_in   = fire && back_push_ok;
  assign back_ctrl.shift_out  = fire && back_pop_ok;
  assign back_ctrl.load       = fire && front_push_ok;

  // loads happen only when not full, so the count fits the cell index
  dq_chain #(
    .DEPTH (CAPACITY),
    .WIDTH (SW)
  ) u_front (
    .clk_i   (clk_i),
    .ctrl_i  (front_ctrl),
    .idx_i   (count_q[IW-1:0]),
    .value_i (value_in),
    .head_o  (front_head)
  );

  dq_chain #(
    .DEPTH (CAPACITY),
    .WIDTH (SW)
  ) u_back (
    .clk_i   (clk_i),
    .ctrl_i  (back_ctrl),
    .idx_i   (count_q[IW-1:0]),
    .value_i (value_in),
    .head_o  (back_head)
  );

  always_comb begin
    pop_d = '0;
    if (front_pop_ok)     pop_d = front_head;
    else if (back_pop_ok) pop_d = back_head;
  end

  always_comb begin
    count_d = count_q;
    if (front_push_ok || back_push_ok)  count_d = count_q + CW'(1);
    else if (front_pop_ok || back_pop_ok) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pop_q    <= pop_d;
      status_q <= status_d;
    end
  end

  // count_q only moves when a new item enters, so it always matches the shown result
  logic [SW+DATA_W-1:0]  pop_ext;
  logic [CW+COUNT_W-1:0] count_ext;

  assign pop_ext   = {{DATA_W{1'b0}}, pop_q};
  assign count_ext = {{COUNT_W{1'b0}}, count_q};

  assign out_o.valid       = out_valid_q;
  assign out_o.pop_value   = pop_ext[DATA_W-1:0];
  assign out_o.status      = status_q;
  assign out_o.now_empty   = is_empty;
  assign out_o.now_full    = is_full;
  assign out_o.entry_count = count_ext[COUNT_W-1:0];

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_empty && (in_i.operation == OP_POP_BACK ||
                          in_i.operation == OP_POP_FRONT))
    |=> (out_valid_q && status_q == ST_EMPTY && pop_q == '0))
    else $error("pop on empty not flagged");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !is_full && (in_i.operation == OP_PUSH_BACK ||
                          in_i.operation == OP_PUSH_FRONT))
    |=> (count_q == $past(count_q) + CW'(1)))
    else $error("accepted push did not add an entry");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_full && (in_i.operation == OP_PUSH_BACK ||
                         in_i.operation == OP_PUSH_FRONT))
    |=> (count_q == $past(count_q) && status_q == ST_FULL))
    else $error("push on full changed the queue");
`endif

endmodule
